@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by the transmitter core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while reset is applied.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that a condition in one cycle implies a condition in the next.
`define ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

@@ hdl/pwir_tx_pkg.sv @@
// ----------------------------------------------------------------------------
// Pulse-width IR transmitter package
// Word types, frame sequencer phases, status codes and register map.
// ----------------------------------------------------------------------------
package pwir_tx_pkg;

    localparam int TICKS_W  = 10;
    localparam int NIBBLE_W = 4;
    localparam int CMD_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = TICKS_W;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_START_TICKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_TICKS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_NIBBLE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_NIBBLE  = 3'd5;

    // Register reset values
    localparam logic [TICKS_W-1:0]  START_TICKS_RST = 10'd520;
    localparam logic [TICKS_W-1:0]  ONE_TICKS_RST   = 10'd260;
    localparam logic [TICKS_W-1:0]  ZERO_TICKS_RST  = 10'd65;
    localparam logic [TICKS_W-1:0]  GAP_TICKS_RST   = 10'd65;
    localparam logic [NIBBLE_W-1:0] MIN_NIBBLE_RST  = 4'h8;
    localparam logic [NIBBLE_W-1:0] MAX_NIBBLE_RST  = 4'hD;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_START     = 3'd1,
        PH_START_BIT = 3'd2,
        PH_BIT_HIGH  = 3'd3,
        PH_BIT_LOW   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_INVALID  = 2'd2,
        ST_BUSY     = 2'd3
    } t_status;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_SEND = 1'b1
    } t_operation;

    typedef struct packed {
        t_operation         operation;
        logic [CMD_W-1:0]   command;
    } t_in_word;

    typedef struct packed {
        logic    led;
        logic    busy_res;
        t_status status;
    } t_out_word;

endpackage

@@ hdl/pulse_width_ir_byte_transmitter_core.sv @@
// ----------------------------------------------------------------------------
// Pulse-width IR byte transmitter core
// Sends a command byte MSB first as a pulse-width frame on an IR carrier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_word) carries one word per
//   timer tick or per send request. A tick word steps the carrier and the
//   frame sequencer and returns the emitter level; a send word starts a frame
//   when idle and the command's high nibble lies in min..max, else it is
//   rejected with a status (invalid is checked before busy).
//   Output channel (o_out_valid / i_out_stall / o_out_word) returns exactly
//   one word per accepted input word, in order.
//   An accepted word's result is registered in the output register, or in
//   the skid register if it is held. Throughput is one word per cycle unless
//   stalled; the sequencer update is one logic pass between state registers.
//   When the receiver stalls, the output register holds its word and one more
//   word lands in a skid register; o_in_stall then rises until the skid
//   register drains.
//   Configuration writes (i_cfg_we / i_cfg_index / i_cfg_data) take effect at
//   the next edge; write only while no word is in flight.
//   Synchronous reset restores the register defaults, idles the sequencer
//   and empties both output registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pulse_width_ir_byte_transmitter_core
    import pwir_tx_pkg::*;
#(
    parameter int FRAME_BITS = 8,
    parameter int COUNT_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_word               i_in_word,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_word              o_out_word,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam logic [FRAME_BITS-1:0] MASK_RST = FRAME_BITS'(1) << (FRAME_BITS - 1);

    // Configuration registers
    logic [TICKS_W-1:0]  r_start_ticks;
    logic [TICKS_W-1:0]  r_one_ticks;
    logic [TICKS_W-1:0]  r_zero_ticks;
    logic [TICKS_W-1:0]  r_gap_ticks;
    logic [NIBBLE_W-1:0] r_min_nibble;
    logic [NIBBLE_W-1:0] r_max_nibble;

    // Sequencer state
    t_phase                 r_phase,   n_phase;
    logic                   r_carrier, n_carrier;
    logic                   r_burst,   n_burst;
    logic [FRAME_BITS-1:0]  r_shift,   n_shift;
    logic [FRAME_BITS-1:0]  r_mask,    n_mask;
    logic [COUNT_BITS-1:0]  r_count,   n_count;

    // Output register and skid register
    logic       r_out_valid;
    t_out_word  r_out;
    logic       r_skid_valid;
    t_out_word  r_skid;

    t_out_word  n_word;
    logic       in_fire;
    logic       out_fire;
    logic       reject_send;

    assign in_fire  = i_in_valid && !r_skid_valid;
    assign out_fire = r_out_valid && !i_out_stall;

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_ticks <= START_TICKS_RST;
            r_one_ticks   <= ONE_TICKS_RST;
            r_zero_ticks  <= ZERO_TICKS_RST;
            r_gap_ticks   <= GAP_TICKS_RST;
            r_min_nibble  <= MIN_NIBBLE_RST;
            r_max_nibble  <= MAX_NIBBLE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_START_TICKS: r_start_ticks <= i_cfg_data;
                REG_ONE_TICKS:   r_one_ticks   <= i_cfg_data;
                REG_ZERO_TICKS:  r_zero_ticks  <= i_cfg_data;
                REG_GAP_TICKS:   r_gap_ticks   <= i_cfg_data;
                REG_MIN_NIBBLE:  r_min_nibble  <= i_cfg_data[NIBBLE_W-1:0];
                REG_MAX_NIBBLE:  r_max_nibble  <= i_cfg_data[NIBBLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state and result for the word at the input. The sequencer falls
    // through start -> start_bit -> bit phases within a single tick, so each
    // block below sees the phase that the block above may have just set.
    always_comb begin
        logic [NIBBLE_W-1:0] nib;
        nib       = i_in_word.command[CMD_W-1:CMD_W-NIBBLE_W];
        n_phase   = r_phase;
        n_carrier = r_carrier;
        n_burst   = r_burst;
        n_shift   = r_shift;
        n_mask    = r_mask;
        n_count   = r_count;
        n_word.led    = 1'b0;
        n_word.status = ST_NONE;

        if (i_in_word.operation == OP_SEND) begin
            // Range check comes first, then busy
            if (nib < r_min_nibble || nib > r_max_nibble) begin
                n_word.status = ST_INVALID;
            end else if (r_phase != PH_IDLE) begin
                n_word.status = ST_BUSY;
            end else begin
                n_shift       = FRAME_BITS'(i_in_word.command);
                n_mask        = MASK_RST;
                n_count       = COUNT_BITS'(r_start_ticks);
                n_phase       = PH_START;
                n_word.status = ST_ACCEPTED;
            end
        end else begin
            n_word.led = r_carrier & r_burst;
            n_carrier  = ~r_carrier;

            // Opening burst: count down, leave when the count goes negative
            if (n_phase == PH_START) begin
                n_burst = 1'b1;
                n_count = n_count - COUNT_BITS'(1);
                if (n_count[COUNT_BITS-1]) begin
                    n_phase = PH_START_BIT;
                end
            end
            // Bit start: load the silent interval for the current bit
            if (n_phase == PH_START_BIT) begin
                n_burst = 1'b0;
                if (n_mask == '0) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_count = ((n_shift & n_mask) != '0) ? COUNT_BITS'(r_one_ticks)
                                                         : COUNT_BITS'(r_zero_ticks);
                    n_phase = PH_BIT_HIGH;
                end
            end
            // Silent interval, then carrier gap
            if (n_phase == PH_BIT_HIGH || n_phase == PH_BIT_LOW) begin
                n_count = n_count - COUNT_BITS'(1);
                if (n_phase == PH_BIT_HIGH && n_count[COUNT_BITS-1]) begin
                    n_burst = 1'b1;
                    n_count = COUNT_BITS'(r_gap_ticks);
                    n_phase = PH_BIT_LOW;
                end
                if (n_phase == PH_BIT_LOW && n_count[COUNT_BITS-1]) begin
                    n_burst = 1'b0;
                    n_mask  = n_mask >> 1;
                    n_phase = PH_START_BIT;
                end
            end
        end

        n_word.busy_res = (n_phase != PH_IDLE);
    end

    // Sequencer state: advance only on an accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_carrier <= 1'b0;
            r_burst   <= 1'b0;
            r_shift   <= '0;
            r_mask    <= MASK_RST;
            r_count   <= '0;
        end else if (in_fire) begin
            r_phase   <= n_phase;
            r_carrier <= n_carrier;
            r_burst   <= n_burst;
            r_shift   <= n_shift;
            r_mask    <= n_mask;
            r_count   <= n_count;
        end
    end

    // Output register with skid: a new word goes straight out when the output
    // register is free or draining, else it parks in the skid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (in_fire) begin
            if (!r_out_valid || out_fire) begin
                r_out <= n_word;
            end else begin
                r_skid <= n_word;
            end
        end
    end

    // Assertions
    assign reject_send = in_fire && (i_in_word.operation == OP_SEND)
                      && (n_word.status != ST_ACCEPTED);

    `ASSERT_CLK(a_skid_behind_out, r_skid_valid |-> r_out_valid, "skid word without output word")
    `ASSERT_CLK(a_idle_no_burst, (r_phase == PH_IDLE) |-> !r_burst, "carrier burst while idle")
    `ASSERT_NEXT(a_accept_shows, in_fire, r_out_valid, "accepted word not presented")
    `ASSERT_NEXT(a_reject_holds, reject_send, $stable({r_phase, r_count}), "frame moved on reject")

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse-width IR byte transmitter testbench
// Drives tick and send words with random gaps and random output stalls, runs
// an in-bench model of the carrier and frame sequencer, and compares every
// returned word field by field against the model's prediction, in order.
// ----------------------------------------------------------------------------
module testbench;
    import pwir_tx_pkg::*;

    localparam int FRAME_BITS = 8;
    localparam int COUNT_BITS = 12;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 40;
    localparam int MAX_REPORTS = 40;

    // Clock, reset and DUT pins; every signal the bench drives starts at a known value.
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  in_valid    = 1'b0;
    t_in_word              in_word     = '0;
    logic                  out_stall   = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = REG_START_TICKS;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_word             o_out_word;

    // Words waiting to be offered and results still owed by the DUT.
    t_in_word  pending_words[$];
    t_out_word expected_results[$];

    // Model copy of the register file.
    logic [TICKS_W-1:0]  cfg_start = START_TICKS_RST;
    logic [TICKS_W-1:0]  cfg_one   = ONE_TICKS_RST;
    logic [TICKS_W-1:0]  cfg_zero  = ZERO_TICKS_RST;
    logic [TICKS_W-1:0]  cfg_gap   = GAP_TICKS_RST;
    logic [NIBBLE_W-1:0] cfg_min   = MIN_NIBBLE_RST;
    logic [NIBBLE_W-1:0] cfg_max   = MAX_NIBBLE_RST;

    // Model copy of the transmitter state.
    t_phase                        tx_phase   = PH_IDLE;
    logic                          carrier_q  = 1'b0;
    logic                          burst_q    = 1'b0;
    logic [FRAME_BITS-1:0]         frame_byte = '0;
    logic [FRAME_BITS-1:0]         bit_sel    = FRAME_BITS'(1) << (FRAME_BITS - 1);
    logic signed [COUNT_BITS-1:0]  tick_left  = '0;

    // Idle controls, written only by the stimulus process.
    bit sender_idle_on   = 1'b1;
    bit receiver_idle_on = 1'b1;
    int hold_reqs        = 0;

    int error_count  = 0;
    int result_count = 0;
    int cycle_count  = 0;

    pulse_width_ir_byte_transmitter_core #(
        .FRAME_BITS(FRAME_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------

    // Step the frame sequencer by one tick; phases fall through in order
    // start, start bit, bit within the same tick.
    function automatic void advance_frame();
        if (tx_phase == PH_START) begin
            burst_q   = 1'b1;
            tick_left = tick_left - 1;
            if (tick_left < 0)
                tx_phase = PH_START_BIT;
        end
        if (tx_phase == PH_START_BIT) begin
            burst_q = 1'b0;
            if (bit_sel == '0) begin
                tx_phase = PH_IDLE;
            end else begin
                tick_left = ((frame_byte & bit_sel) != '0) ? COUNT_BITS'(cfg_one)
                                                           : COUNT_BITS'(cfg_zero);
                tx_phase  = PH_BIT_HIGH;
            end
        end
        if (tx_phase == PH_BIT_HIGH || tx_phase == PH_BIT_LOW) begin
            tick_left = tick_left - 1;
            if (tx_phase == PH_BIT_HIGH && tick_left < 0) begin
                burst_q   = 1'b1;
                tick_left = COUNT_BITS'(cfg_gap);
                tx_phase  = PH_BIT_LOW;
            end
            if (tx_phase == PH_BIT_LOW && tick_left < 0) begin
                burst_q  = 1'b0;
                bit_sel  = bit_sel >> 1;
                tx_phase = PH_START_BIT;
            end
        end
    endfunction

    // Work out the word the DUT returns for one accepted input word.
    function automatic t_out_word predict_emitter_word(input t_in_word w);
        t_out_word           r;
        logic [NIBBLE_W-1:0] nib;
        r   = '0;
        nib = w.command[CMD_W-1 -: NIBBLE_W];
        if (w.operation == OP_SEND) begin
            // Range is checked before busy.
            if (nib < cfg_min || nib > cfg_max) begin
                r.status = ST_INVALID;
            end else if (tx_phase != PH_IDLE) begin
                r.status = ST_BUSY;
            end else begin
                frame_byte = FRAME_BITS'(w.command);
                bit_sel    = FRAME_BITS'(1) << (FRAME_BITS - 1);
                tick_left  = COUNT_BITS'(cfg_start);
                tx_phase   = PH_START;
                r.status   = ST_ACCEPTED;
            end
        end else begin
            r.led     = carrier_q & burst_q;
            carrier_q = ~carrier_q;
            r.status  = ST_NONE;
            advance_frame();
        end
        r.busy_res = (tx_phase != PH_IDLE);
        return r;
    endfunction

    // Enough ticks from a send for the sequencer to be idle again.
    function automatic int frame_ticks(input logic [CMD_W-1:0] cmd);
        int total;
        total = int'(cfg_start) + 1;
        for (int b = FRAME_BITS - 1; b >= 0; b--)
            total += (cmd[b] ? int'(cfg_one) : int'(cfg_zero)) + int'(cfg_gap) + 2;
        return total;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offer queued words, predict each one at the accepting edge
    // ------------------------------------------------------------------------
    int send_wait = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall)
                expected_results.push_back(predict_emitter_word(in_word));
            // Hold a stalled word; otherwise wait out the gap or offer the next.
            if (!in_valid || !o_in_stall) begin
                if (send_wait > 0) begin
                    send_wait--;
                    in_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    in_word   <= pending_words.pop_front();
                    in_valid  <= 1'b1;
                    send_wait = sender_idle_on ? int'($urandom_range(0, 6)) : 0;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check accepted result words, drive the output stall
    // ------------------------------------------------------------------------
    int hold_seen  = 0;
    int hold_left  = 0;
    int stall_left = 0;

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        if (error_count < MAX_REPORTS)
            $display("mismatch on result %0d: %s expected %0d got %0d",
                     result_count, what, exp_v, got_v);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected word, queue depth", 0, 1);
                end else begin
                    exp_w = expected_results.pop_front();
                    if (o_out_word.led !== exp_w.led)
                        report_mismatch("led", exp_w.led, o_out_word.led);
                    if (o_out_word.busy_res !== exp_w.busy_res)
                        report_mismatch("busy_res", exp_w.busy_res, o_out_word.busy_res);
                    if (o_out_word.status !== exp_w.status)
                        report_mismatch("status", exp_w.status, o_out_word.status);
                end
                result_count++;
                stall_left = receiver_idle_on ? int'($urandom_range(0, 6)) : 0;
            end
            // A long hold lets the DUT fill its output and skid registers.
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Give up on a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic push_send(input logic [CMD_W-1:0] cmd);
        pending_words.push_back('{operation: OP_SEND, command: cmd});
    endtask

    // Tick words carry junk in the command field; the DUT must ignore it.
    task automatic push_ticks(input int n);
        for (int k = 0; k < n; k++)
            pending_words.push_back('{operation: OP_TICK, command: CMD_W'($urandom)});
    endtask

    // Wait until every word is offered, accepted and answered. Check on the
    // falling edge, once the driver and monitor have settled for the cycle.
    task automatic drain();
        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_START_TICKS: cfg_start = data;
            REG_ONE_TICKS:   cfg_one   = data;
            REG_ZERO_TICKS:  cfg_zero  = data;
            REG_GAP_TICKS:   cfg_gap   = data;
            REG_MIN_NIBBLE:  cfg_min   = data[NIBBLE_W-1:0];
            REG_MAX_NIBBLE:  cfg_max   = data[NIBBLE_W-1:0];
            default: ;
        endcase
    endtask

    // Write all six registers; nibble registers get junk in their upper bits.
    task automatic write_all(input int start_v, input int one_v, input int zero_v,
                             input int gap_v, input int min_v, input int max_v);
        write_reg(REG_START_TICKS, CFG_DATA_W'(start_v));
        write_reg(REG_ONE_TICKS,   CFG_DATA_W'(one_v));
        write_reg(REG_ZERO_TICKS,  CFG_DATA_W'(zero_v));
        write_reg(REG_GAP_TICKS,   CFG_DATA_W'(gap_v));
        write_reg(REG_MIN_NIBBLE,  {6'($urandom), 4'(min_v)});
        write_reg(REG_MAX_NIBBLE,  {6'($urandom), 4'(max_v)});
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Send a command and tick until its frame is over, plus a little slack.
    task automatic send_frame(input logic [CMD_W-1:0] cmd, input int extra);
        push_send(cmd);
        push_ticks(frame_ticks(cmd) + extra);
    endtask

    // Mostly whole frames with random content, with stray sends mixed in
    // and some frames cut short so the next send lands while busy.
    task automatic random_phase(input int target);
        int                  made;
        int                  n;
        logic [CMD_W-1:0]    cmd;
        logic [NIBBLE_W-1:0] nib;
        made = 0;
        while (made < target) begin
            if (cfg_min <= cfg_max && $urandom_range(0, 9) != 0) begin
                nib = NIBBLE_W'($urandom_range(cfg_min, cfg_max));
                cmd = {nib, 4'($urandom)};
                push_send(cmd);
                n = frame_ticks(cmd);
                if ($urandom_range(0, 5) == 0)
                    n = $urandom_range(0, n);
                else
                    n = n + $urandom_range(0, 2);
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(0, 11) == 0) begin
                        push_send(CMD_W'($urandom));
                        made++;
                    end
                    push_ticks(1);
                end
                made += n + 1;
            end else begin
                push_send(CMD_W'($urandom));
                n = $urandom_range(0, 3);
                push_ticks(n);
                made += n + 1;
            end
        end
    endtask

    task automatic random_regs();
        int lo;
        int hi;
        int swap;
        lo = $urandom_range(0, 15);
        hi = $urandom_range(0, 15);
        // Keep the range ordered most of the time; otherwise leave it inverted.
        if (lo > hi && $urandom_range(0, 4) != 0) begin
            swap = lo;
            lo   = hi;
            hi   = swap;
        end
        if ($urandom_range(0, 3) == 0)
            write_all($urandom_range(0, 40), $urandom_range(0, 30),
                      $urandom_range(0, 30), $urandom_range(0, 30), lo, hi);
        else
            write_all($urandom_range(0, 6), $urandom_range(0, 9),
                      $urandom_range(0, 4), $urandom_range(0, 5), lo, hi);
    endtask

    initial begin
        int random_items;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset register values: nibble bounds, invalid before busy, and a
        // full frame at the default timing.
        push_ticks(2);
        push_send(8'h7F);
        push_send(8'hE0);
        push_send(8'h80);
        push_send(8'hD5);
        push_send(8'h75);
        push_ticks(frame_ticks(8'h80) + 2);
        drain();

        // All timings at zero; upper bound of the default range accepted.
        write_all(0, 0, 0, 0, 8, 13);
        send_frame(8'hDF, 1);
        drain();

        // Inverted range rejects everything.
        write_all(0, 1, 0, 1, 15, 0);
        push_send(8'h00);
        push_send(8'hFF);
        push_send(8'h5A);
        push_ticks(2);
        drain();

        // Full range: extremes of the command and a send while busy.
        write_all(1, 0, 1, 0, 0, 15);
        push_send(8'h00);
        push_send(8'hFF);
        push_ticks(frame_ticks(8'h00) + 1);
        send_frame(8'hFF, 1);
        drain();

        // Random phases; hold the receiver off in some of them.
        random_items = 0;
        for (int p = 0; random_items < 700; p++) begin
            random_regs();
            sender_idle_on   = ($urandom_range(0, 3) != 0);
            receiver_idle_on = ($urandom_range(0, 3) != 0);
            random_phase(110);
            random_items += 110;
            if (p % 3 == 0) begin
                repeat (3) @(posedge i_clk);
                hold_reqs++;
            end
            // Pause the sender until every result is back.
            drain();
        end

        // Longest burst and longest one bit; single-nibble range.
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b1;
        write_all(1023, 1023, 0, 0, 8, 8);
        push_send(8'h90);
        send_frame(8'h80, 2);
        drain();

        // Wait out the pipeline before the verdict.
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
